### src/ffd_pkg.sv
`timescale 1ns / 1ps

package ffd_pkg;

  localparam int unsigned MAX_FRAG_BYTES = 31;
  localparam int unsigned HDR_BYTES      = 8;

  localparam int unsigned LEN_W  = $clog2(MAX_FRAG_BYTES + 1);
  localparam int unsigned IDX_W  = (MAX_FRAG_BYTES > 1) ? $clog2(MAX_FRAG_BYTES) : 1;
  localparam int unsigned HC_W   = $clog2(HDR_BYTES);
  localparam int unsigned CAP_W  = 13;
  localparam int unsigned PART_W = 16;

  localparam logic [7:0]       SYNC_A    = 8'hAA;
  localparam logic [7:0]       SYNC_B    = 8'h55;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

  typedef enum logic [1:0] {
    S_FIRST = 2'd0,
    S_NEXT  = 2'd1,
    S_DATA  = 2'd2,
    S_DRAIN = 2'd3
  } state_e;

  typedef enum logic [2:0] {
    ERR_SYNC      = 3'd0,
    ERR_LENGTH    = 3'd1,
    ERR_NOT_FIRST = 3'd2,
    ERR_CHECKSUM  = 3'd3,
    ERR_SEQUENCE  = 3'd4,
    ERR_OVERFLOW  = 3'd5
  } err_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_ERROR   = 1'b1
  } kind_e;

  typedef struct packed {
    logic hdr_wr;
    logic hdr_load;
    logic first;
    logic data_wr;
    logic drain_start;
    logic drain_step;
    logic commit;
    logic err_emit;
    err_e err_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hdr_last;
    logic hdr_err;
    err_e hdr_code;
    logic data_more;
    logic chk_ok;
    logic drain_last;
    logic last_part;
    logic out_free;
  } dp_status_t;

endpackage

### src/ffd_ctrl.sv
`timescale 1ns / 1ps

module ffd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ffd_pkg::dp_status_t   status_i,
  output ffd_pkg::ctrl_cmd_t    cmd_o,
  output ffd_pkg::state_e       state_o
);

  ffd_pkg::state_e state_q, state_d;
  logic            accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffd_pkg::S_FIRST;
    end else begin
      state_q <= state_d;
    end
  end

  assign accept  = in_valid_i && in_ready_o;
  assign state_o = state_q;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ffd_pkg::S_FIRST, ffd_pkg::S_NEXT: begin
        in_ready_o  = status_i.out_free;
        cmd_o.first = (state_q == ffd_pkg::S_FIRST);
        if (accept) begin
          cmd_o.hdr_wr = 1'b1;
          if (status_i.hdr_last) begin
            if (status_i.hdr_err) begin
              cmd_o.err_emit = 1'b1;
              cmd_o.err_code = status_i.hdr_code;
              state_d        = ffd_pkg::S_FIRST;
            end else begin
              cmd_o.hdr_load = 1'b1;
              state_d        = ffd_pkg::S_DATA;
            end
          end
        end
      end
      ffd_pkg::S_DATA: begin
        in_ready_o = status_i.out_free;
        if (accept) begin
          if (status_i.data_more) begin
            cmd_o.data_wr = 1'b1;
          end else if (!status_i.chk_ok) begin
            cmd_o.err_emit = 1'b1;
            cmd_o.err_code = ffd_pkg::ERR_CHECKSUM;
            state_d        = ffd_pkg::S_FIRST;
          end else begin
            cmd_o.drain_start = 1'b1;
            state_d           = ffd_pkg::S_DRAIN;
          end
        end
      end
      ffd_pkg::S_DRAIN: begin
        if (status_i.out_free) begin
          cmd_o.drain_step = 1'b1;
          if (status_i.drain_last) begin
            cmd_o.commit = !status_i.last_part;
            state_d      = status_i.last_part ? ffd_pkg::S_FIRST : ffd_pkg::S_NEXT;
          end
        end
      end
      default: begin
        state_d = ffd_pkg::S_FIRST;
      end
    endcase
  end

endmodule

### src/ffd_datapath.sv
`timescale 1ns / 1ps

module ffd_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffd_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic [7:0]                  rx_byte_i,
  input  ffd_pkg::ctrl_cmd_t          cmd_i,
  output ffd_pkg::dp_status_t         status_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        item_kind_o,
  output logic [7:0]                  payload_byte_o,
  output logic [2:0]                  error_code_o,
  output logic                        end_of_run_o,
  output logic                        message_done_o,
  output logic [ffd_pkg::CAP_W-1:0]   message_length_o
);

  // header bytes 0..6; byte 7 is taken straight from the link
  logic [7:0] hdr_q [ffd_pkg::HDR_BYTES-1];
  logic [7:0] frag_mem [ffd_pkg::MAX_FRAG_BYTES];

  logic [ffd_pkg::HC_W-1:0]   hc_q;
  logic [ffd_pkg::CAP_W-1:0]  cap_q;
  logic [ffd_pkg::LEN_W-1:0]  flen_q;
  logic [ffd_pkg::LEN_W-1:0]  bidx_q;
  logic [ffd_pkg::LEN_W-1:0]  didx_q;
  logic [7:0]                 xor_q;
  logic [ffd_pkg::PART_W-1:0] cur_q;
  logic [ffd_pkg::PART_W-1:0] tot_q;
  logic [ffd_pkg::CAP_W-1:0]  stored_q;

  logic                       out_valid_q;
  ffd_pkg::kind_e             out_kind_q;
  logic [7:0]                 out_byte_q;
  ffd_pkg::err_e              out_code_q;
  logic                       out_eor_q;
  logic                       out_done_q;
  logic [ffd_pkg::CAP_W-1:0]  out_len_q;

  logic [15:0]                f_len, f_part, f_total;
  logic [16:0]                need;
  logic                       sync_bad, len_bad, first_bad, seq_bad, cap_bad;
  logic [ffd_pkg::CAP_W-1:0]  total_len;
  logic                       out_load;

  assign f_len   = {hdr_q[2], hdr_q[3]};
  assign f_part  = {hdr_q[5], hdr_q[4]};
  assign f_total = {rx_byte_i, hdr_q[6]};

  assign sync_bad  = (hdr_q[0] != ffd_pkg::SYNC_A) || (hdr_q[1] != ffd_pkg::SYNC_B);
  assign len_bad   = (f_len == 16'd0) || (f_len > 16'(ffd_pkg::MAX_FRAG_BYTES));
  assign first_bad = (f_part != 16'd1) || (f_total == 16'd0);
  assign seq_bad   = (17'(f_part) != 17'(cur_q) + 17'd1) || (f_total != tot_q);
  assign need      = 17'(stored_q) + 17'(f_len) + 17'd1;
  assign cap_bad   = need > 17'(cap_q);

  always_comb begin
    status_o.hdr_err  = 1'b1;
    status_o.hdr_code = ffd_pkg::ERR_SYNC;
    if (sync_bad) begin
      status_o.hdr_code = ffd_pkg::ERR_SYNC;
    end else if (len_bad) begin
      status_o.hdr_code = ffd_pkg::ERR_LENGTH;
    end else if (cmd_i.first) begin
      status_o.hdr_code = ffd_pkg::ERR_NOT_FIRST;
      status_o.hdr_err  = first_bad;
    end else if (seq_bad) begin
      status_o.hdr_code = ffd_pkg::ERR_SEQUENCE;
    end else begin
      status_o.hdr_code = ffd_pkg::ERR_OVERFLOW;
      status_o.hdr_err  = cap_bad;
    end
  end

  assign total_len           = stored_q + ffd_pkg::CAP_W'(flen_q);
  assign status_o.hdr_last   = (hc_q == ffd_pkg::HC_W'(ffd_pkg::HDR_BYTES - 1));
  assign status_o.data_more  = (bidx_q < flen_q);
  assign status_o.chk_ok     = (rx_byte_i == xor_q);
  assign status_o.drain_last = (didx_q == flen_q - ffd_pkg::LEN_W'(1));
  assign status_o.last_part  = (cur_q == tot_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_load = cmd_i.err_emit || cmd_i.drain_step;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q        <= '0;
      cap_q       <= ffd_pkg::CAP_RESET;
      bidx_q      <= '0;
      didx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (cmd_i.hdr_wr) begin
        hc_q <= hc_q + 1'b1;
      end
      if (cmd_i.hdr_load) begin
        bidx_q <= '0;
      end else if (cmd_i.data_wr) begin
        bidx_q <= bidx_q + 1'b1;
      end
      if (cmd_i.drain_start) begin
        didx_q <= '0;
      end else if (cmd_i.drain_step) begin
        didx_q <= didx_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers and fragment buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_wr && !status_o.hdr_last) begin
      hdr_q[hc_q] <= rx_byte_i;
    end
    if (cmd_i.hdr_load) begin
      flen_q <= f_len[ffd_pkg::LEN_W-1:0];
      xor_q  <= 8'h00;
      if (cmd_i.first) begin
        cur_q    <= 16'd1;
        tot_q    <= f_total;
        stored_q <= '0;
      end else begin
        cur_q <= f_part;
      end
    end
    if (cmd_i.data_wr) begin
      frag_mem[bidx_q[ffd_pkg::IDX_W-1:0]] <= rx_byte_i;
      xor_q                                <= xor_q ^ rx_byte_i;
    end
    if (cmd_i.commit) begin
      stored_q <= total_len;
    end
    if (cmd_i.err_emit) begin
      out_kind_q <= ffd_pkg::KIND_ERROR;
      out_byte_q <= 8'h00;
      out_code_q <= cmd_i.err_code;
      out_eor_q  <= 1'b1;
      out_done_q <= 1'b0;
      out_len_q  <= '0;
    end else if (cmd_i.drain_step) begin
      out_kind_q <= ffd_pkg::KIND_PAYLOAD;
      out_byte_q <= frag_mem[didx_q[ffd_pkg::IDX_W-1:0]];
      out_code_q <= ffd_pkg::ERR_SYNC;   // code field reads zero on payload beats
      out_eor_q  <= status_o.drain_last;
      out_done_q <= status_o.drain_last && status_o.last_part;
      out_len_q  <= (status_o.drain_last && status_o.last_part) ? total_len : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_kind_o      = out_kind_q;
  assign payload_byte_o   = out_byte_q;
  assign error_code_o     = out_code_q;
  assign end_of_run_o     = out_eor_q;
  assign message_done_o   = out_done_q;
  assign message_length_o = out_len_q;

endmodule

### src/fragmented_frame_deframer.sv
`timescale 1ns / 1ps

// Fragmented message deframer with per-fragment XOR checksum.
// Input channel: one link byte per beat on rx_byte_i (in_valid_i / in_ready_o).
// Output channel: one result per beat (out_valid_o / out_ready_i), either a
// verified payload byte or an error report; end_of_run_o marks the last beat
// caused by one input byte, message_done_o and message_length_o the final byte
// of a whole message.
// Throughput: header, payload and checksum bytes are taken one per cycle while
// the output register is free. After a good checksum byte the intake closes and
// the fragment buffer drains one byte per cycle while the output register is
// free, so a fragment of L payload bytes takes 9 + L link bytes. An error
// report goes into the output register with the byte that causes it; payload
// beats follow from the drain state. A stalled receiver holds the output
// register; intake and drain wait on it, nothing is dropped. Reset: waits for a
// first header, capacity back at 256 bytes. The user must write configuration
// (cfg_we_i / cfg_wdata_i) only while the block is idle; it is not enforced.
module fragmented_frame_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ffd_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        item_kind_o,
  output logic [7:0]                  payload_byte_o,
  output logic [2:0]                  error_code_o,
  output logic                        end_of_run_o,
  output logic                        message_done_o,
  output logic [ffd_pkg::CAP_W-1:0]   message_length_o
);

  ffd_pkg::ctrl_cmd_t  cmd;
  ffd_pkg::dp_status_t status;
  ffd_pkg::state_e     state;

  // sequencer: header / data / drain phases
  ffd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // header checks, fragment buffer, counters and the output register
  ffd_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .rx_byte_i        (rx_byte_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .item_kind_o      (item_kind_o),
    .payload_byte_o   (payload_byte_o),
    .error_code_o     (error_code_o),
    .end_of_run_o     (end_of_run_o),
    .message_done_o   (message_done_o),
    .message_length_o (message_length_o)
  );

  // an error report closes its run and never finishes a message
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o |-> end_of_run_o && !message_done_o)
    else $error("error beat with bad run flags");

  // a finished message ends the run and carries a nonzero length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |-> end_of_run_o && (message_length_o != '0))
    else $error("message end without run end or length");

  // no link byte is taken while the buffer drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state == ffd_pkg::S_DRAIN |-> !in_ready_o)
    else $error("intake open during drain");

  // a drain step always leaves a payload beat in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.drain_step |=> out_valid_o && !item_kind_o && (error_code_o == 3'd0))
    else $error("drain step lost its beat");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ffd_pkg::*;

  localparam int unsigned DRAIN_WAIT  = 40;     // longest fragment drain plus margin
  localparam int unsigned HOLD_CYCLES = 300;    // receiver back-pressure stretch
  localparam int unsigned LIMIT       = 500000; // watchdog, far above the slowest run
  localparam int unsigned NROWS       = 25;
  localparam int unsigned NPHASES     = 6;
  localparam int unsigned PHASE_BYTES = 40;     // random link bytes per capacity setting

  typedef enum logic [1:0] {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;
  typedef enum int {
    FAULT_NONE, FAULT_SYNC, FAULT_LEN, FAULT_PART, FAULT_TOTAL, FAULT_CHK, FAULT_NOISE
  } fault_e;

  // One output beat as the receiver should see it.
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       data;
    err_e             code;
    logic             eor;
    logic             done;
    logic [CAP_W-1:0] total;
  } beat_t;

  // One directed fragment: optional capacity write first, then header fields.
  // Where typed is set the fragment must end in that error report.
  typedef struct packed {
    logic             cfg;
    logic [CAP_W-1:0] cap;
    logic [15:0]      sync;
    logic [15:0]      len;
    logic [15:0]      part;
    logic [15:0]      total;
    fill_e            fill;
    logic             bad_chk;
    logic             typed;
    err_e             err;
  } frag_row_t;

  localparam frag_row_t DIR_ROWS [NROWS] = '{
    // header rejects straight from idle
    '{1'b0, 13'd0, 16'hAA54, 16'd1,     16'd1,     16'd1,     FILL_RAND, 1'b0, 1'b1, ERR_SYNC},
    '{1'b0, 13'd0, 16'h0055, 16'd1,     16'd1,     16'd1,     FILL_RAND, 1'b0, 1'b1, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd0,     16'd1,     16'd1,     FILL_RAND, 1'b0, 1'b1, ERR_LENGTH},
    '{1'b0, 13'd0, 16'hAA55, 16'd32,    16'd1,     16'd1,     FILL_RAND, 1'b0, 1'b1, ERR_LENGTH},
    '{1'b0, 13'd0, 16'hAA55, 16'h011F,  16'd1,     16'd1,     FILL_RAND, 1'b0, 1'b1, ERR_LENGTH},
    '{1'b0, 13'd0, 16'hAA55, 16'd1,     16'd2,     16'd1,     FILL_RAND, 1'b0, 1'b1, ERR_NOT_FIRST},
    '{1'b0, 13'd0, 16'hAA55, 16'd1,     16'd1,     16'd0,     FILL_RAND, 1'b0, 1'b1, ERR_NOT_FIRST},
    '{1'b0, 13'd0, 16'hAA55, 16'd1,     16'h0101,  16'd2,     FILL_RAND, 1'b0, 1'b1, ERR_NOT_FIRST},
    // shortest whole message, a numbering skip, a changed count and a bad checksum
    '{1'b0, 13'd0, 16'hAA55, 16'd1,     16'd1,     16'd1,     FILL_ZERO, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd31,    16'd1,     16'd3,     FILL_ONES, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd31,    16'd3,     16'd3,     FILL_RAND, 1'b0, 1'b1, ERR_SEQUENCE},
    '{1'b0, 13'd0, 16'hAA55, 16'd31,    16'd1,     16'd3,     FILL_RAND, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd5,     16'd2,     16'd4,     FILL_RAND, 1'b0, 1'b1, ERR_SEQUENCE},
    '{1'b0, 13'd0, 16'hAA55, 16'd5,     16'd1,     16'd2,     FILL_RAND, 1'b1, 1'b1, ERR_CHECKSUM},
    // two full fragments, 62 bytes in all, then a count change mid-message
    '{1'b0, 13'd0, 16'hAA55, 16'd31,    16'd1,     16'd2,     FILL_RAND, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd31,    16'd2,     16'd2,     FILL_RAND, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd20,    16'd1,     16'hFFFF,  FILL_RAND, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd7,     16'd2,     16'hFFFF,  FILL_RAND, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd4,     16'd3,     16'hFFFE,  FILL_RAND, 1'b0, 1'b1, ERR_SEQUENCE},
    // zero capacity: first fragment passes unchecked, the next overflows
    '{1'b1, 13'd0, 16'hAA55, 16'd10,    16'd1,     16'd3,     FILL_RAND, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd1,     16'd2,     16'd3,     FILL_RAND, 1'b0, 1'b1, ERR_OVERFLOW},
    // capacity 12: 5 + 6 + 1 fits exactly, one more byte does not
    '{1'b1, 13'd12, 16'hAA55, 16'd5,    16'd1,     16'd3,     FILL_RAND, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd6,     16'd2,     16'd3,     FILL_RAND, 1'b0, 1'b0, ERR_SYNC},
    '{1'b0, 13'd0, 16'hAA55, 16'd1,     16'd3,     16'd3,     FILL_RAND, 1'b0, 1'b1, ERR_OVERFLOW},
    '{1'b1, 13'd8191, 16'hAA55, 16'd31, 16'd1,     16'd1,     FILL_RAND, 1'b0, 1'b0, ERR_SYNC}
  };

  localparam logic [CAP_W-1:0] PHASE_CAPS [NPHASES-1] = '{
    13'd1, 13'd24, 13'd60, 13'd4096, 13'd8191
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [7:0]       rx_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             item_kind_o;
  logic [7:0]       payload_byte_o;
  logic [2:0]       error_code_o;
  logic             end_of_run_o;
  logic             message_done_o;
  logic [CAP_W-1:0] message_length_o;

  fragmented_frame_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .item_kind_o      (item_kind_o),
    .payload_byte_o   (payload_byte_o),
    .error_code_o     (error_code_o),
    .end_of_run_o     (end_of_run_o),
    .message_done_o   (message_done_o),
    .message_length_o (message_length_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shared test state
  beat_t       expected_beats [$];
  int          n_fail   = 0;
  int unsigned n_sent   = 0;
  int unsigned n_cycles = 0;
  logic        tx_calm  = 1'b0;  // sender offers back to back
  logic        rx_calm  = 1'b0;  // receiver always ready
  logic        hold_req = 1'b0;  // one long receiver stall

  // Deframer model state
  state_e           rx_phase = S_FIRST;
  int unsigned      hdr_fill = 0;
  logic [7:0]       hdr_bytes  [HDR_BYTES];
  logic [7:0]       frag_bytes [MAX_FRAG_BYTES];
  int unsigned      frag_len  = 0;
  int unsigned      data_pos  = 0;
  logic [7:0]       chk_acc   = 8'h00;
  int unsigned      part_no   = 0;
  int unsigned      part_cnt  = 0;
  int unsigned      msg_bytes = 0;
  logic [CAP_W-1:0] cap_reg   = CAP_RESET;

  // What the last accepted byte produced, for the typed rows
  int    step_beats = 0;
  kind_e step_kind  = KIND_PAYLOAD;
  err_e  step_code  = ERR_SYNC;

  function automatic void back_to_hunt();
    rx_phase  = S_FIRST;
    hdr_fill  = 0;
    msg_bytes = 0;
    part_no   = 0;
    part_cnt  = 0;
  endfunction

  function automatic void post_beat(kind_e k, logic [7:0] d, err_e c, logic eor,
                                    logic done, logic [CAP_W-1:0] n);
    beat_t bt;
    bt = '{k, d, c, eor, done, n};
    expected_beats.push_back(bt);
    step_beats++;
    step_kind = k;
    step_code = c;
  endfunction

  // Any failure: one report, partial message dropped, hunt for a first header.
  function automatic void flag_error(err_e c);
    post_beat(KIND_ERROR, 8'h00, c, 1'b1, 1'b0, '0);
    back_to_hunt();
  endfunction

  // Advance the model by one link byte and queue the beats it releases.
  function automatic void deframe_byte(logic [7:0] b);
    int unsigned len;
    int unsigned part;
    int unsigned tot;
    int unsigned sum;
    logic        last;
    step_beats = 0;

    if (rx_phase == S_DATA) begin
      if (data_pos < frag_len) begin
        frag_bytes[data_pos] = b;
        chk_acc ^= b;
        data_pos++;
        return;
      end
      // checksum byte
      if (b != chk_acc) begin
        flag_error(ERR_CHECKSUM);
        return;
      end
      last = (part_no == part_cnt);
      sum  = msg_bytes + frag_len;
      // code field reads as zero on payload beats
      for (int i = 0; i < frag_len; i++)
        post_beat(KIND_PAYLOAD, frag_bytes[i], ERR_SYNC, i == frag_len - 1,
                  last && (i == frag_len - 1),
                  (last && (i == frag_len - 1)) ? CAP_W'(sum) : '0);
      if (last) begin
        back_to_hunt();
      end else begin
        msg_bytes = sum;
        rx_phase  = S_NEXT;
        hdr_fill  = 0;
      end
      return;
    end

    if (rx_phase != S_NEXT) rx_phase = S_FIRST;
    hdr_bytes[hdr_fill] = b;
    hdr_fill = (hdr_fill + 1) % HDR_BYTES;
    if (hdr_fill != 0) return;

    // length big-endian, number and count little-endian
    len  = {hdr_bytes[2], hdr_bytes[3]};
    part = {hdr_bytes[5], hdr_bytes[4]};
    tot  = {hdr_bytes[7], hdr_bytes[6]};

    if (hdr_bytes[0] != SYNC_A || hdr_bytes[1] != SYNC_B) begin
      flag_error(ERR_SYNC);
    end else if (len == 0 || len > MAX_FRAG_BYTES) begin
      flag_error(ERR_LENGTH);
    end else if (rx_phase == S_FIRST && (part != 1 || tot == 0)) begin
      flag_error(ERR_NOT_FIRST);
    end else if (rx_phase == S_NEXT && (part != part_no + 1 || tot != part_cnt)) begin
      flag_error(ERR_SEQUENCE);
    end else if (rx_phase == S_NEXT && msg_bytes + len + 1 > cap_reg) begin
      // first fragment never checked against capacity
      flag_error(ERR_OVERFLOW);
    end else begin
      if (rx_phase == S_FIRST) begin
        part_cnt  = tot;
        msg_bytes = 0;
      end
      part_no  = part;
      frag_len = len;
      data_pos = 0;
      chk_acc  = 8'h00;
      rx_phase = S_DATA;
    end
  endfunction

  function automatic void match_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      n_fail++;
    end
  endfunction

  // Monitor: all sampling at the rising edge, model first, then the beat check.
  beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) cap_reg = cfg_wdata_i;
      if (in_valid_i && in_ready_o) deframe_byte(rx_byte_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got kind %0d byte %0h code %0d",
                   $time, item_kind_o, payload_byte_o, error_code_o);
          n_fail++;
        end else begin
          want = expected_beats.pop_front();
          match_field("item_kind",      want.kind,  item_kind_o);
          match_field("payload_byte",   want.data,  payload_byte_o);
          match_field("error_code",     want.code,  error_code_o);
          match_field("end_of_run",     want.eor,   end_of_run_o);
          match_field("message_done",   want.done,  message_done_o);
          match_field("message_length", want.total, message_length_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random ready gaps per beat, plus one long hold on request.
  initial begin : receiver
    int w;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      w = rx_calm ? 0 : $urandom_range(0, 15);
      if (w != 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      @(negedge clk_i);
    end
  end

  // Sender: called at a falling edge, returns at the falling edge after the beat
  // is taken. Valid is left high; the caller either offers the next byte at once
  // or drops it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Capacity is only touched with nothing in flight.
  task automatic write_cap(logic [CAP_W-1:0] v);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Header, then payload and checksum only if the model accepted the header.
  task automatic send_fragment(logic [15:0] sync, logic [15:0] len, logic [15:0] part,
                               logic [15:0] tot, fill_e fill, logic bad_chk);
    logic [7:0] chk;
    logic [7:0] d;
    send_byte(sync[15:8]);
    send_byte(sync[7:0]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    send_byte(part[7:0]);
    send_byte(part[15:8]);
    send_byte(tot[7:0]);
    send_byte(tot[15:8]);
    if (rx_phase == S_DATA) begin
      chk = 8'h00;
      for (int i = 0; i < frag_len; i++) begin
        case (fill)
          FILL_ZERO: d = 8'h00;
          FILL_ONES: d = 8'hFF;
          default:   d = 8'($urandom);
        endcase
        chk ^= d;
        send_byte(d);
      end
      if (bad_chk) chk ^= 8'h01 << $urandom_range(0, 7);
      send_byte(chk);
    end
  endtask

  // Bring the link back to a header boundary outside any payload.
  task automatic resync_stream();
    while (rx_phase == S_DATA || hdr_fill != 0) send_byte(8'($urandom));
  endtask

  // Mostly well-formed messages of 1..4 fragments, now and then one fault.
  task automatic send_message();
    int          n_parts;
    int          plen;
    logic [15:0] total;
    logic [15:0] tot;
    logic [15:0] sync;
    logic [15:0] len;
    logic [15:0] part;
    fault_e      fault;
    n_parts = $urandom_range(1, 4);
    // rare huge count leaves the message open for the next one to trip over
    total = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(5, 65535)) : 16'(n_parts);
    for (int p = 1; p <= n_parts; p++) begin
      plen  = ($urandom_range(0, 5) == 0) ? MAX_FRAG_BYTES : $urandom_range(1, 8);
      sync  = {SYNC_A, SYNC_B};
      len   = 16'(plen);
      part  = 16'(p);
      tot   = total;
      fault = ($urandom_range(0, 7) == 0) ?
              fault_e'($urandom_range(FAULT_SYNC, FAULT_NOISE)) : FAULT_NONE;
      case (fault)
        FAULT_SYNC:  sync ^= 16'd1 << $urandom_range(0, 15);
        FAULT_LEN:   len = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(32, 65535));
        FAULT_PART:  part ^= 16'd1 << $urandom_range(0, 15);
        FAULT_TOTAL: tot ^= 16'd1 << $urandom_range(0, 15);
        FAULT_NOISE: begin
          repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
          resync_stream();
        end
        default: ;
      endcase
      send_fragment(sync, len, part, tot, FILL_RAND, fault == FAULT_CHK);
      if (rx_phase != S_NEXT) break;
    end
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // nothing may be on offer straight after reset
    if (out_valid_o !== 1'b0) begin
      $display("%0t: out_valid after reset, expected 0, got %0b", $time, out_valid_o);
      n_fail++;
    end

    // Directed fragments
    for (int r = 0; r < NROWS; r++) begin
      if (DIR_ROWS[r].cfg) write_cap(DIR_ROWS[r].cap);
      send_fragment(DIR_ROWS[r].sync, DIR_ROWS[r].len, DIR_ROWS[r].part,
                    DIR_ROWS[r].total, DIR_ROWS[r].fill, DIR_ROWS[r].bad_chk);
      if (DIR_ROWS[r].typed &&
          (step_beats != 1 || step_kind != KIND_ERROR || step_code != DIR_ROWS[r].err)) begin
        $display("%0t: row %0d error report, expected code %0d, got %0d beats code %0d",
                 $time, r, DIR_ROWS[r].err, step_beats, step_code);
        n_fail++;
      end
    end

    // Random traffic, one capacity setting per phase
    for (int p = 0; p < NPHASES; p++) begin
      write_cap((p == NPHASES - 1) ? CAP_W'($urandom_range(0, 8191)) : PHASE_CAPS[p]);
      tx_calm  = (p == 2) || (p == 4);
      rx_calm  = (p == 4);
      hold_req = (p == 2);  // sender keeps offering while the output is held off
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_BYTES) begin
        resync_stream();
        send_message();
      end
    end

    in_valid_i <= 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    if (n_fail == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
